// ===== design/dtpw_pkg.sv =====
// Shared types and constants for the depth test pixel writer.
`timescale 1ns / 1ps
`default_nettype none

package dtpw_pkg;

    // Default sizes of the target frame and of one stored depth.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int DEPTH_BITS_DEF = 16;

    // Fixed field widths of the ports.
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int COORD_W     = 12;
    localparam int IN_DEPTH_W  = 16;
    localparam int COLOR_W     = 24;
    localparam int PIX_W       = 8;

    // Coordinates and frame sizes are compared at this width; it holds 4096.
    localparam int CMP_W = 13;

    // Output buffer.
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Reset value of both frame size registers.
    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 9'd256;

    // One pixel write.
    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } pixel_t;

endpackage

`default_nettype wire

// ===== design/dtpw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dtpw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                                          aclk,
    input  wire logic                                          wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  wire logic [WIDTH-1:0]                              wr_data,
    input  wire logic                                          rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic      [WIDTH-1:0]                              rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents when the same entry is written that cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/dtpw_out_fifo.sv =====
// Small output buffer that holds pixel writes until the sink takes them.
`timescale 1ns / 1ps
`default_nettype none

module dtpw_out_fifo
    import dtpw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire pixel_t               push_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pixel_t                    m_data,
    output logic [OUT_CNT_W-1:0]      count
);
    pixel_t                 mem_reg [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign count   = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == OUT_CNT_W'(OUT_FIFO_DEPTH) |-> !push || pop)
        else $error("output buffer overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("output buffer count lost a push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= OUT_CNT_W'(OUT_FIFO_DEPTH))
        else $error("output buffer count out of range");

endmodule

`default_nettype wire

// ===== design/depth_test_pixel_writer_core.sv =====
// Top level of the depth test pixel writer: frame check, depth store and pixel output.
`timescale 1ns / 1ps
`default_nettype none
// A fragment that draws passes the stage 1 and stage 2 registers and is then pushed
// into the output buffer, whose registered count raises m_valid for its pixel beat.
// Throughput: one fragment per cycle while the output side drains, set by the single
// read-modify-write pass through the depth RAM; same-pixel hits back to back are forwarded.
// A clear beat holds off input until it leaves stage 2 and the sweep of the store ends.
// Reset (aresetn low, synchronous) sets both frame sizes to 256 and then sweeps all
// MAX_WIDTH*MAX_HEIGHT depth RAM entries to zero, one entry per cycle, before s_ready rises.

module depth_test_pixel_writer_core
    import dtpw_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,
    // Input channel.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [COORD_W-1:0]    s_frag_x,
    input  wire logic [COORD_W-1:0]    s_frag_y,
    input  wire logic [IN_DEPTH_W-1:0] s_frag_depth,
    input  wire logic [COLOR_W-1:0]    s_frag_color,
    // Result channel.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PIX_W-1:0]           m_pixel_x,
    output logic [PIX_W-1:0]           m_pixel_y,
    output logic [COLOR_W-1:0]         m_pixel_color
);
    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW    = DEPTH_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);

    // Configuration registers.
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_SIZE_RESET;
            frame_height_reg <= FRAME_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Effective frame size saturates at the size of the depth store.
    logic [WW-1:0] eff_width;
    logic [HW-1:0] eff_height;

    assign eff_width  = (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH)) ?
                        WW'(MAX_WIDTH) : WW'(frame_width_reg);
    assign eff_height = (CMP_W'(frame_height_reg) > CMP_W'(MAX_HEIGHT)) ?
                        HW'(MAX_HEIGHT) : HW'(frame_height_reg);

    // Stage 0: frame check and pixel address, computed from the beat on the input.
    // A negative coordinate fails on its sign bit; the rest compares as unsigned.
    logic             in_x, in_y;
    logic [XW-1:0]    ux;
    logic [YW-1:0]    uy;
    logic [WW+YW-1:0] row_base;
    logic [WW+YW:0]   addr_sum;
    logic             s_accept;

    assign in_x = !s_frag_x[COORD_W-1] &&
                  (CMP_W'(s_frag_x[COORD_W-2:0]) < CMP_W'(eff_width));
    assign in_y = !s_frag_y[COORD_W-1] &&
                  (CMP_W'(s_frag_y[COORD_W-2:0]) < CMP_W'(eff_height));
    assign ux       = XW'(s_frag_x[COORD_W-2:0]);
    assign uy       = YW'(s_frag_y[COORD_W-2:0]);
    assign row_base = eff_width * uy;
    assign addr_sum = {1'b0, row_base} + (WW + YW + 1)'(ux);
    assign s_accept = s_valid && s_ready;

    // Stage 1 issues the depth read; stage 2 compares and writes back.
    logic          s1_valid_reg, s1_clear_reg, s1_in_frame_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [DW-1:0] s1_depth_reg;
    pixel_t        s1_pix_reg;

    logic          s2_valid_reg, s2_clear_reg, s2_in_frame_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [DW-1:0] s2_depth_reg;
    pixel_t        s2_pix_reg;
    logic          s2_fwd_valid_reg, s2_fwd_valid_next;
    logic [DW-1:0] s2_fwd_depth_reg;

    // Clear sweep over the whole store.
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clear_ptr_reg, clear_ptr_next;

    logic [DW-1:0] ram_rd_data;
    logic [DW-1:0] stored_depth;
    logic          s2_wins;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;

    logic [OUT_CNT_W-1:0] out_count;
    logic [OUT_CNT_W:0]   occupancy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_clear_reg     <= s_op;
        s1_in_frame_reg  <= in_x && in_y;
        s1_addr_reg      <= AW'(addr_sum);
        s1_depth_reg     <= DW'(s_frag_depth);
        s1_pix_reg       <= '{x: s_frag_x[PIX_W-1:0], y: s_frag_y[PIX_W-1:0],
                              color: s_frag_color};
        s2_clear_reg     <= s1_clear_reg;
        s2_in_frame_reg  <= s1_in_frame_reg;
        s2_addr_reg      <= s1_addr_reg;
        s2_depth_reg     <= s1_depth_reg;
        s2_pix_reg       <= s1_pix_reg;
        s2_fwd_valid_reg <= s2_fwd_valid_next;
        s2_fwd_depth_reg <= s2_depth_reg;
    end

    // The RAM read in stage 1 misses a write to the same entry in that very cycle,
    // so the written depth is carried along into stage 2 instead.
    assign s2_fwd_valid_next = s2_wins && (s2_addr_reg == s1_addr_reg);
    assign stored_depth      = s2_fwd_valid_reg ? s2_fwd_depth_reg : ram_rd_data;

    // A tie never wins, so a depth of zero never draws over a cleared entry.
    assign s2_wins = s2_valid_reg && !s2_clear_reg && s2_in_frame_reg &&
                     (s2_depth_reg > stored_depth);

    // The sweep and a winning fragment never overlap: input is held off while
    // the sweep runs, and the sweep starts only once the clear beat leaves stage 2.
    assign ram_wr_en   = clearing_reg || s2_wins;
    assign ram_wr_addr = clearing_reg ? clear_ptr_reg : s2_addr_reg;
    assign ram_wr_data = clearing_reg ? '0 : s2_depth_reg;

    always_comb begin
        clearing_next  = clearing_reg;
        clear_ptr_next = clear_ptr_reg;
        if (clearing_reg) begin
            if (clear_ptr_reg == LAST_ADDR) begin
                clearing_next  = 1'b0;
                clear_ptr_next = '0;
            end else begin
                clear_ptr_next = clear_ptr_reg + 1'b1;
            end
        end else if (s2_valid_reg && s2_clear_reg) begin
            clearing_next  = 1'b1;
            clear_ptr_next = '0;
        end
    end

    // The sweep also runs right after reset, so the store starts out all zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clear_ptr_reg <= '0;
        end else begin
            clearing_reg  <= clearing_next;
            clear_ptr_reg <= clear_ptr_next;
        end
    end

    dtpw_ram #(
        .WIDTH (DW),
        .DEPTH (STORE)
    ) u_depth_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s1_valid_reg),
        .rd_addr (s1_addr_reg),
        .rd_data (ram_rd_data)
    );

    // Every beat in flight may still produce a pixel, so the output buffer
    // reserves a slot for each before a new beat is taken. This keeps the
    // pipeline free of stalls while a finished pixel waits on the m_ side.
    assign occupancy = (OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(s1_valid_reg)
                     + (OUT_CNT_W + 1)'(s2_valid_reg);

    assign s_ready = !clearing_reg &&
                     !(s1_valid_reg && s1_clear_reg) &&
                     !(s2_valid_reg && s2_clear_reg) &&
                     (occupancy < (OUT_CNT_W + 1)'(OUT_FIFO_DEPTH));

    pixel_t out_pix;

    dtpw_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s2_wins),
        .push_data (s2_pix_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_pix),
        .count     (out_count)
    );

    assign m_pixel_x     = out_pix.x;
    assign m_pixel_y     = out_pix.y;
    assign m_pixel_color = out_pix.color;

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(clearing_reg && s2_wins))
        else $error("fragment write collided with the clear sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s1_valid_reg && !s2_valid_reg)
        else $error("beat in flight during the clear sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= (OUT_CNT_W + 1)'(OUT_FIFO_DEPTH))
        else $error("more beats in flight than output slots");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_clear_reg |=> clearing_reg && clear_ptr_reg == '0)
        else $error("clear beat did not start the sweep");

endmodule

`default_nettype wire

// ===== sim/tb_depth_test_pixel_writer_core.sv =====
// Self-checking testbench for the depth test pixel writer core.
`timescale 1ns / 1ps

module tb_depth_test_pixel_writer_core
    import dtpw_pkg::*;
();

    // Item kinds carried on s_op.
    localparam logic OP_FRAGMENT = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    // A drawing fragment shows up once it has passed stages 1 and 2 and the output buffer.
    // Allow a margin on top of that before a register write or the final verdict.
    localparam int DRAIN_CYCLES = 8;

    // A clear beat stalls the input for a full sweep of the store, and the reset sweep is nearly as
    // long. No handshake for several times that long means the block has hung.
    localparam int STALL_LIMIT = 400000;

    localparam int STORE_SIZE = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int PHASE_BEATS = 200;

    // The testbench's own copy of the depth store and frame registers. A clear beat zeroes
    // it; a beat that draws updates it and queues the pixel write that the block should produce.
    class depth_mirror;
        int          width_reg;
        int          height_reg;
        bit [15:0]   level [STORE_SIZE];
        pixel_t      writes_due [$];
        int          errors;

        function new();
            width_reg  = int'(FRAME_SIZE_RESET);
            height_reg = int'(FRAME_SIZE_RESET);
            foreach (level[i]) level[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_FRAME_WIDTH) width_reg = int'(val);
            else if (idx == REG_FRAME_HEIGHT) height_reg = int'(val);
        endfunction

        // Registers above the store's size saturate at the maximum.
        function int eff_w();
            return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
        endfunction

        function int eff_h();
            return (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
        endfunction

        // Store address of a pixel, or -1 when the coordinates fall outside the frame.
        function int pixel_addr(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            int sx;
            int sy;
            int ew;
            int eh;
            sx = int'($signed(x));
            sy = int'($signed(y));
            ew = eff_w();
            eh = eff_h();
            if (sx < 0 || sy < 0 || sx >= ew || sy >= eh) return -1;
            return ew * sy + sx;
        endfunction

        function bit [15:0] level_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            int a;
            a = pixel_addr(x, y);
            return (a < 0) ? 16'd0 : level[a];
        endfunction

        function void note_beat(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [IN_DEPTH_W-1:0] depth, logic [COLOR_W-1:0] color);
            int     a;
            pixel_t px;
            if (op == OP_CLEAR) begin
                foreach (level[i]) level[i] = '0;
                return;
            end
            a = pixel_addr(x, y);
            // A tie never wins, so depth zero cannot draw on a cleared pixel.
            if (a < 0 || depth <= level[a]) return;
            level[a]  = depth;
            px.x      = x[PIX_W-1:0];
            px.y      = y[PIX_W-1:0];
            px.color  = color;
            writes_due = {writes_due, px};
        endfunction

        function void check_write(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                                  logic [COLOR_W-1:0] color);
            pixel_t want;
            if (writes_due.size() == 0) begin
                $display("%0t: pixel write with none expected: x=%0d y=%0d color=%06h",
                         $time, x, y, color);
                errors++;
                return;
            end
            want = writes_due.pop_front();
            if (x !== want.x) begin
                $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, x);
                errors++;
            end
            if (y !== want.y) begin
                $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, y);
                errors++;
            end
            if (color !== want.color) begin
                $display("%0t: pixel_color expected %06h actual %06h",
                         $time, want.color, color);
                errors++;
            end
        endfunction
    endclass

    // Every input is known from time zero; reset is held low from the start.
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_W-1:0]      cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_op         = OP_FRAGMENT;
    logic [COORD_W-1:0]    s_frag_x     = '0;
    logic [COORD_W-1:0]    s_frag_y     = '0;
    logic [IN_DEPTH_W-1:0] s_frag_depth = '0;
    logic [COLOR_W-1:0]    s_frag_color = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [PIX_W-1:0]      m_pixel_x;
    logic [PIX_W-1:0]      m_pixel_y;
    logic [COLOR_W-1:0]    m_pixel_color;

    // Percent of cycles in which each side holds back.
    int send_idle = 0;
    int recv_idle = 0;

    int idle_cycles = 0;
    logic [COORD_W-1:0] last_x = '0;
    logic [COORD_W-1:0] last_y = '0;

    depth_mirror zmirror = new();

    depth_test_pixel_writer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_frag_x      (s_frag_x),
        .s_frag_y      (s_frag_y),
        .s_frag_depth  (s_frag_depth),
        .s_frag_color  (s_frag_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver decides on each falling edge whether to stall the next cycle.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle);
    end

    // Both channels are sampled at the rising edge. An output beat can never belong to
    // an input beat of the same edge, so checking first and predicting second is safe.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) zmirror.check_write(m_pixel_x, m_pixel_y, m_pixel_color);
            if (s_valid && s_ready)
                zmirror.note_beat(s_op, s_frag_x, s_frag_y, s_frag_depth, s_frag_color);
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Offers one beat and returns on the falling edge after it is taken. Valid is only
    // dropped for a random gap, never between back-to-back beats.
    task automatic send_beat(input logic op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [IN_DEPTH_W-1:0] depth,
                             input logic [COLOR_W-1:0] color);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_op         = op;
        s_frag_x     = x;
        s_frag_y     = y;
        s_frag_depth = depth;
        s_frag_color = color;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Brings the block to rest: every pixel write delivered, dropped fragments flushed
    // out of the pipeline, and any clear walk finished, which shows as s_ready high.
    task automatic settle();
        s_valid = 1'b0;
        while (zmirror.writes_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = val[CFG_W-1:0];
        zmirror.set_reg(idx, val[CFG_W-1:0]);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Random fragment. Most land in a small corner of the frame so that pixels are hit
    // again and again and the depth compare is exercised both ways. Some repeat the
    // previous pixel to force back-to-back hits, some sit on the frame border, and the
    // rest spread over the frame or the whole coordinate range.
    function automatic void pick_fragment(output logic [COORD_W-1:0] x,
                                          output logic [COORD_W-1:0] y,
                                          output logic [IN_DEPTH_W-1:0] depth);
        int ew;
        int eh;
        int wx;
        int wy;
        int r;
        int vx;
        int vy;
        bit [15:0] cur;
        ew = zmirror.eff_w();
        eh = zmirror.eff_h();
        wx = (ew == 0 || ew > 16) ? 16 : ew;
        wy = (eh == 0 || eh > 16) ? 16 : eh;
        r  = $urandom_range(99);
        if (r < 60) begin
            vx = $urandom_range(wx - 1);
            vy = $urandom_range(wy - 1);
        end else if (r < 70) begin
            vx = int'($signed(last_x));
            vy = int'($signed(last_y));
        end else if (r < 80) begin
            case ($urandom_range(2))
                0: vx = ew - 1;
                1: vx = ew;
                default: vx = 0;
            endcase
            case ($urandom_range(2))
                0: vy = eh - 1;
                1: vy = eh;
                default: vy = 0;
            endcase
        end else if (r < 90) begin
            vx = (ew == 0) ? $urandom_range(15) : $urandom_range(ew - 1);
            vy = (eh == 0) ? $urandom_range(15) : $urandom_range(eh - 1);
        end else begin
            vx = $urandom_range(4095);
            vy = $urandom_range(4095);
        end
        x = vx[COORD_W-1:0];
        y = vy[COORD_W-1:0];

        // Depth: a few tiny values, exact ties, one above the stored value, else anything.
        cur = zmirror.level_at(x, y);
        r   = $urandom_range(99);
        if (r < 10) depth = IN_DEPTH_W'($urandom_range(3));
        else if (r < 20) depth = cur;
        else if (r < 30) depth = (cur == 16'hffff) ? cur : cur + 16'd1;
        else depth = IN_DEPTH_W'($urandom_range(65535));
        last_x = x;
        last_y = y;
    endfunction

    // One random phase under a frame setting. A clear beat may be dropped in before a random
    // one of the beats; each one costs a full walk of the store.
    task automatic run_phase(input int w, input int h, input int beats, input bit with_clear);
        int clear_at;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [IN_DEPTH_W-1:0] depth;
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        clear_at = with_clear ? $urandom_range(beats - 1) : -1;
        for (int i = 0; i < beats; i++) begin
            if (i == clear_at)
                send_beat(OP_CLEAR, COORD_W'($urandom_range(4095)),
                          COORD_W'($urandom_range(4095)),
                          IN_DEPTH_W'($urandom_range(65535)),
                          COLOR_W'($urandom_range(24'hffffff)));
            pick_fragment(x, y, depth);
            send_beat(OP_FRAGMENT, x, y, depth, COLOR_W'($urandom_range(24'hffffff)));
        end
    endtask

    initial begin
        // Frame settings per random phase, with the extremes: a single pixel, empty
        // frames, registers above the store's size, and the full 256 in each direction.
        int widths  [9] = '{16, 1, 0, 511, 5, 100, 256, 256, 1};
        int heights [9] = '{8, 1, 5, 300, 0, 37, 256, 1, 256};

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // The first third runs with a lazy sender and a very lazy receiver.
        send_idle = 25;
        recv_idle = 83;
        settle();

        // Directed beats at the reset frame size of 256 by 256.
        send_beat(OP_FRAGMENT, 12'd0,   12'd0,   16'd1,     24'h000000);
        send_beat(OP_FRAGMENT, 12'd0,   12'd0,   16'd1,     24'hffffff); // tie, dropped
        send_beat(OP_FRAGMENT, 12'd1,   12'd0,   16'd0,     24'hffffff); // depth zero
        send_beat(OP_FRAGMENT, 12'd255, 12'd255, 16'hffff,  24'hffffff);
        send_beat(OP_FRAGMENT, 12'd256, 12'd0,   16'hffff,  24'h123456); // right of frame
        send_beat(OP_FRAGMENT, 12'd0,   12'd256, 16'hffff,  24'h123456); // below frame
        send_beat(OP_FRAGMENT, 12'hfff, 12'd0,   16'hffff,  24'h654321); // x of -1
        send_beat(OP_FRAGMENT, 12'd0,   12'h800, 16'hffff,  24'h654321); // y of -2048
        send_beat(OP_FRAGMENT, 12'h7ff, 12'h7ff, 16'hffff,  24'habcdef);
        send_beat(OP_FRAGMENT, 12'h800, 12'd5,   16'hffff,  24'habcdef);
        // Same pixel back to back: a rise, a loss, a tie and a final win.
        send_beat(OP_FRAGMENT, 12'd3,   12'd4,   16'd100,   24'h0000ff);
        send_beat(OP_FRAGMENT, 12'd3,   12'd4,   16'd200,   24'h00ff00);
        send_beat(OP_FRAGMENT, 12'd3,   12'd4,   16'd150,   24'hff0000);
        send_beat(OP_FRAGMENT, 12'd3,   12'd4,   16'd200,   24'hff00ff);
        send_beat(OP_FRAGMENT, 12'd3,   12'd4,   16'd201,   24'h00ffff);
        send_beat(OP_FRAGMENT, 12'd4,   12'd3,   16'hffff,  24'h123456);
        send_beat(OP_FRAGMENT, 12'd4,   12'd3,   16'hffff,  24'h000000); // tie at the top
        // After a clear every pixel draws again, even at depth one.
        send_beat(OP_CLEAR,    12'hfff, 12'hfff, 16'hffff,  24'hffffff);
        send_beat(OP_FRAGMENT, 12'd0,   12'd0,   16'd1,     24'h555555);
        send_beat(OP_FRAGMENT, 12'd255, 12'd255, 16'd1,     24'haaaaaa);
        send_beat(OP_FRAGMENT, 12'd3,   12'd4,   16'd1,     24'h0f0f0f);
        send_beat(OP_FRAGMENT, 12'd128, 12'd200, 16'h8000,  24'hf0f0f0);

        // Random phases: three settings for each idling pattern, and a clear in the
        // middle setting of each group.
        for (int p = 0; p < 9; p++) begin
            if (p == 3) begin
                send_idle = 83;
                recv_idle = 25;
            end else if (p == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            run_phase(widths[p], heights[p], PHASE_BEATS, (p % 3) == 1);
        end

        // Drain, let the pipeline empty out, then give the verdict.
        settle();
        if (zmirror.errors == 0 && zmirror.writes_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
